// ===== src/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared types and codes of the pairing session code check
// Request and result payloads, request/error/reason codes, session states.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Request types
  localparam logic [3:0] REQ_BEGIN        = 4'd0;
  localparam logic [3:0] REQ_BEGIN_BOUND  = 4'd1;
  localparam logic [3:0] REQ_XPORT_READY  = 4'd2;
  localparam logic [3:0] REQ_XCRIPT_DONE  = 4'd3;
  localparam logic [3:0] REQ_CONFIRM      = 4'd4;
  localparam logic [3:0] REQ_SUBMIT       = 4'd5;
  localparam logic [3:0] REQ_COMPLETE     = 4'd6;
  localparam logic [3:0] REQ_CANCEL       = 4'd7;
  localparam logic [3:0] REQ_REJECT       = 4'd8;
  localparam logic [3:0] REQ_FAIL         = 4'd9;
  localparam logic [3:0] REQ_EXPIRY_CHECK = 4'd10;

  // Error codes
  localparam logic [2:0] ERR_OK            = 3'd0;
  localparam logic [2:0] ERR_ACTIVE_EXISTS = 3'd1;
  localparam logic [2:0] ERR_BAD_FP        = 3'd2;
  localparam logic [2:0] ERR_INV_STATE     = 3'd3;
  localparam logic [2:0] ERR_BAD_CODE      = 3'd4;
  localparam logic [2:0] ERR_NOT_FOUND     = 3'd5;
  localparam logic [2:0] ERR_EXPIRED       = 3'd6;
  localparam logic [2:0] ERR_EXHAUSTED     = 3'd7;

  // Failure reasons
  localparam logic [2:0] RSN_NONE      = 3'd0;
  localparam logic [2:0] RSN_ATTEMPTS  = 3'd1;
  localparam logic [2:0] RSN_CANCELLED = 3'd2;
  localparam logic [2:0] RSN_EXPIRED   = 3'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_VALIDITY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'd1;

  // Largest six-digit code plus one
  localparam logic [19:0] CODE_LIMIT = 20'd1000000;

  // Session states, one-hot
  typedef enum logic [8:0] {
    ST_NONE       = 9'b0_0000_0001,
    ST_REQUESTING = 9'b0_0000_0010,
    ST_EXCHANGING = 9'b0_0000_0100,
    ST_AWAIT_CMP  = 9'b0_0000_1000,
    ST_CONFIRMING = 9'b0_0001_0000,
    ST_COMPLETED  = 9'b0_0010_0000,
    ST_EXPIRED    = 9'b0_0100_0000,
    ST_REJECTED   = 9'b0_1000_0000,
    ST_FAILED     = 9'b1_0000_0000
  } sess_state_t;

  // External state codes
  localparam logic [3:0] SCODE_NONE       = 4'd0;
  localparam logic [3:0] SCODE_REQUESTING = 4'd1;
  localparam logic [3:0] SCODE_EXCHANGING = 4'd2;
  localparam logic [3:0] SCODE_AWAIT_CMP  = 4'd3;
  localparam logic [3:0] SCODE_CONFIRMING = 4'd4;
  localparam logic [3:0] SCODE_COMPLETED  = 4'd5;
  localparam logic [3:0] SCODE_EXPIRED    = 4'd6;
  localparam logic [3:0] SCODE_REJECTED   = 4'd7;
  localparam logic [3:0] SCODE_FAILED     = 4'd8;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] now_seconds;
    logic [63:0] session_id;
    logic [31:0] expiry_time;
    logic [7:0]  fingerprint_bytes;
    logic        code_present;
    logic        code_well_formed;
    logic [19:0] code_value;
    logic [2:0]  reason_code;
  } psc_req_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic       expired_now;
    logic [3:0] session_state;
    logic [2:0] failure_reason;
    logic [7:0] attempts_left;
    logic       changed;
  } psc_rsp_t;

  function automatic logic [3:0] state_code(sess_state_t s);
    logic [3:0] c;
    unique case (s)
      ST_NONE:       c = SCODE_NONE;
      ST_REQUESTING: c = SCODE_REQUESTING;
      ST_EXCHANGING: c = SCODE_EXCHANGING;
      ST_AWAIT_CMP:  c = SCODE_AWAIT_CMP;
      ST_CONFIRMING: c = SCODE_CONFIRMING;
      ST_COMPLETED:  c = SCODE_COMPLETED;
      ST_EXPIRED:    c = SCODE_EXPIRED;
      ST_REJECTED:   c = SCODE_REJECTED;
      ST_FAILED:     c = SCODE_FAILED;
      default:       c = SCODE_NONE;
    endcase
    return c;
  endfunction

  function automatic logic is_terminal(sess_state_t s);
    return (s == ST_COMPLETED) || (s == ST_EXPIRED) ||
           (s == ST_REJECTED) || (s == ST_FAILED);
  endfunction

endpackage

// ===== src/psc_req_if.sv =====
// ----------------------------------------------------------------------------
// psc_req_if: request channel
// Valid/ready channel carrying one session request.
// ----------------------------------------------------------------------------
interface psc_req_if;
  import psc_pkg::*;

  logic     valid;
  logic     ready;
  psc_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/psc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// psc_rsp_if: result channel
// Valid/ready channel carrying one request result.
// ----------------------------------------------------------------------------
interface psc_rsp_if;
  import psc_pkg::*;

  logic     valid;
  logic     ready;
  psc_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/pairing_session_code_check_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// pairing_session_code_check_fsm_unit: one pairing session with code check
// A request passes the request register, then the result register, to the result.
// Throughput: one transaction per cycle unless the result side stalls; the session
// update happens in one pass of compare/add/decrement logic between the request
// and result stages.
// Reset: synchronous, active low; no session, validity 300 s, 3 attempts.
// ----------------------------------------------------------------------------
module pairing_session_code_check_fsm_unit #(
  parameter int unsigned ID_BITS         = 64,
  parameter int unsigned FINGERPRINT_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  psc_req_if.sink                           in_req,
  psc_rsp_if.source                         out_rsp
);
  import psc_pkg::*;

  localparam logic [7:0] FP_LEN = 8'(FINGERPRINT_LEN);

  // Configuration registers
  logic [15:0] validity_r;
  logic [7:0]  max_att_r;

  // Request stage
  logic     req_valid_r;
  psc_req_t req_r;

  // Result stage
  logic     out_valid_r;
  psc_rsp_t out_r;

  // Session state
  logic               sess_valid_r, sess_valid_nxt;
  sess_state_t        state_r, state_nxt;
  logic [ID_BITS-1:0] active_id_r, active_id_nxt;
  logic [19:0]        code_r, code_nxt;
  logic [31:0]        expires_r, expires_nxt;
  logic [7:0]         att_r, att_nxt;
  logic [2:0]         reason_r, reason_nxt;

  psc_rsp_t rsp_nxt;

  logic               advance;
  logic [ID_BITS-1:0] req_id;
  logic               exp_hit;
  logic               id_match;
  logic               live_after;
  logic               code_bad;
  logic [32:0]        limit;
  logic [32:0]        exp_req;
  logic               is_action;
  logic [7:0]         att_dec;

  // Advance the request stage whenever the result stage is free or draining.
  assign advance      = req_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !req_valid_r || advance;

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;

  // Configuration writes; the user must issue them only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      validity_r <= 16'd300;
      max_att_r  <= 8'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VALIDITY:     validity_r <= cfg_wdata;
        CFG_MAX_ATTEMPTS: max_att_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_r <= in_req.data;
    end
  end

  // Shared terms of the request decode
  assign req_id     = req_r.session_id[ID_BITS-1:0];
  // A live session expires once the current time reaches its expiry.
  assign exp_hit    = sess_valid_r && !is_terminal(state_r) &&
                      (req_r.now_seconds >= expires_r);
  assign id_match   = sess_valid_r && (req_id != '0) && (req_id == active_id_r);
  assign live_after = sess_valid_r && !is_terminal(state_r) && !exp_hit;
  // A code flagged well formed but out of six-digit range is still malformed.
  assign code_bad   = (req_r.code_value >= CODE_LIMIT) ||
                      (req_r.code_present && !req_r.code_well_formed);
  // Keep now + validity in 33 bits for the bound check.
  assign limit      = {1'b0, req_r.now_seconds} + {17'd0, validity_r};
  assign exp_req    = (req_r.req_type == REQ_BEGIN_BOUND) ?
                      {1'b0, req_r.expiry_time} : limit;
  assign is_action  = (req_r.req_type >= REQ_XPORT_READY) &&
                      (req_r.req_type <= REQ_FAIL);
  assign att_dec    = att_r - 8'd1;

  // Session update and result for the request in the request stage
  always_comb begin
    sess_valid_nxt = sess_valid_r;
    state_nxt      = state_r;
    active_id_nxt  = active_id_r;
    code_nxt       = code_r;
    expires_nxt    = expires_r;
    att_nxt        = att_r;
    reason_nxt     = reason_r;
    rsp_nxt        = '0;
    rsp_nxt.error_code = ERR_OK;

    priority if ((req_r.req_type == REQ_BEGIN) || (req_r.req_type == REQ_BEGIN_BOUND)) begin
      // Expire first, whatever the outcome of the begin.
      if (exp_hit) begin
        state_nxt           = ST_EXPIRED;
        reason_nxt          = RSN_EXPIRED;
        rsp_nxt.expired_now = 1'b1;
        rsp_nxt.changed     = 1'b1;
      end
      priority if (live_after) begin
        rsp_nxt.error_code = ERR_ACTIVE_EXISTS;
      end else if (req_r.fingerprint_bytes != FP_LEN) begin
        rsp_nxt.error_code = ERR_BAD_FP;
      end else if ((validity_r == 16'd0) || (max_att_r == 8'd0)) begin
        rsp_nxt.error_code = ERR_INV_STATE;
      end else if (code_bad) begin
        rsp_nxt.error_code = ERR_BAD_CODE;
      end else if ((req_id == '0) || (exp_req <= {1'b0, req_r.now_seconds}) ||
                   (exp_req > limit)) begin
        rsp_nxt.error_code = ERR_INV_STATE;
      end else begin
        sess_valid_nxt  = 1'b1;
        active_id_nxt   = req_id;
        state_nxt       = ST_REQUESTING;
        code_nxt        = req_r.code_value;
        // Saturate the expiry at the top of the 32-bit time range.
        expires_nxt     = exp_req[32] ? 32'hFFFF_FFFF : exp_req[31:0];
        att_nxt         = max_att_r;
        reason_nxt      = RSN_NONE;
        rsp_nxt.changed = 1'b1;
      end
    end else if (is_action) begin
      priority if (!id_match) begin
        rsp_nxt.error_code = ERR_NOT_FOUND;
      end else if (exp_hit) begin
        state_nxt           = ST_EXPIRED;
        reason_nxt          = RSN_EXPIRED;
        rsp_nxt.expired_now = 1'b1;
        rsp_nxt.changed     = 1'b1;
        rsp_nxt.error_code  = ERR_EXPIRED;
      end else begin
        unique case (req_r.req_type)
          REQ_XPORT_READY: begin
            if (state_r == ST_REQUESTING) begin
              state_nxt       = ST_EXCHANGING;
              rsp_nxt.changed = 1'b1;
            end else begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end
          end
          REQ_XCRIPT_DONE: begin
            if (state_r == ST_EXCHANGING) begin
              state_nxt       = ST_AWAIT_CMP;
              rsp_nxt.changed = 1'b1;
            end else begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end
          end
          REQ_CONFIRM: begin
            if (state_r == ST_AWAIT_CMP) begin
              state_nxt       = ST_CONFIRMING;
              rsp_nxt.changed = 1'b1;
            end else begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end
          end
          REQ_COMPLETE: begin
            if (state_r == ST_CONFIRMING) begin
              state_nxt       = ST_COMPLETED;
              rsp_nxt.changed = 1'b1;
            end else begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end
          end
          REQ_SUBMIT: begin
            priority if (state_r != ST_AWAIT_CMP) begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end else if (!req_r.code_well_formed || (req_r.code_value >= CODE_LIMIT)) begin
              rsp_nxt.error_code = ERR_BAD_CODE;
            end else if (req_r.code_value != code_r) begin
              // Wrong code: use up an attempt; the last one rejects.
              att_nxt         = att_dec;
              rsp_nxt.changed = 1'b1;
              if (att_dec == 8'd0) begin
                state_nxt          = ST_REJECTED;
                reason_nxt         = RSN_ATTEMPTS;
                rsp_nxt.error_code = ERR_EXHAUSTED;
              end else begin
                rsp_nxt.error_code = ERR_BAD_CODE;
              end
            end else begin
              state_nxt       = ST_CONFIRMING;
              rsp_nxt.changed = 1'b1;
            end
          end
          REQ_CANCEL: begin
            if (is_terminal(state_r)) begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end else begin
              state_nxt       = ST_REJECTED;
              reason_nxt      = RSN_CANCELLED;
              rsp_nxt.changed = 1'b1;
            end
          end
          REQ_REJECT, REQ_FAIL: begin
            if (is_terminal(state_r) || (req_r.reason_code == RSN_NONE)) begin
              rsp_nxt.error_code = ERR_INV_STATE;
            end else begin
              state_nxt       = (req_r.req_type == REQ_FAIL) ? ST_FAILED : ST_REJECTED;
              reason_nxt      = req_r.reason_code;
              rsp_nxt.changed = 1'b1;
            end
          end
          default: rsp_nxt.error_code = ERR_INV_STATE;
        endcase
      end
    end else if (req_r.req_type == REQ_EXPIRY_CHECK) begin
      if (exp_hit) begin
        state_nxt           = ST_EXPIRED;
        reason_nxt          = RSN_EXPIRED;
        rsp_nxt.expired_now = 1'b1;
        rsp_nxt.changed     = 1'b1;
      end
    end else begin
      // Unknown request types
      rsp_nxt.error_code = ERR_INV_STATE;
    end

    // Publish the session snapshot after this request.
    rsp_nxt.session_state  = sess_valid_nxt ? state_code(state_nxt) : SCODE_NONE;
    rsp_nxt.failure_reason = sess_valid_nxt ? reason_nxt : RSN_NONE;
    rsp_nxt.attempts_left  = sess_valid_nxt ? att_nxt : 8'd0;
  end

  // Session state: commit when the request moves into the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_valid_r <= 1'b0;
      state_r      <= ST_NONE;
      active_id_r  <= '0;
      code_r       <= '0;
      expires_r    <= '0;
      att_r        <= '0;
      reason_r     <= RSN_NONE;
    end else if (advance) begin
      sess_valid_r <= sess_valid_nxt;
      state_r      <= state_nxt;
      active_id_r  <= active_id_nxt;
      code_r       <= code_nxt;
      expires_r    <= expires_nxt;
      att_r        <= att_nxt;
      reason_r     <= reason_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= rsp_nxt;
    end
  end

`ifndef SYNTHESIS
  // Once opened, a session slot never returns to empty.
  a_sess_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sess_valid_r |=> sess_valid_r)
    else $error("session valid dropped");

  // The session only moves when the request reports a change.
  a_no_silent_change: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !rsp_nxt.changed) |=> $stable(state_r) && $stable(att_r) &&
                                      $stable(reason_r))
    else $error("session changed without changed flag");

  // An expiry reported by a result leaves the session expired, or freshly
  // reopened by the begin that expired the old one.
  a_expired_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.expired_now) |-> out_r.changed &&
      (((out_r.session_state == SCODE_EXPIRED) &&
        (out_r.failure_reason == RSN_EXPIRED)) ||
       ((out_r.session_state == SCODE_REQUESTING) &&
        (out_r.failure_reason == RSN_NONE))))
    else $error("expired result without expired state");

  // Backpressure on the request side only comes from a held request.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (req_valid_r && out_valid_r && !out_rsp.ready))
    else $error("request stalled without cause");
`endif

endmodule

// ===== dv/pairing_session_code_check_fsm_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pairing_session_code_check_fsm_unit_tb: self-checking bench of the session FSM
// Drives directed and random session requests through the request channel with
// random gaps and back-pressure, predicts every result with a behavioral copy
// of the session logic, and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module pairing_session_code_check_fsm_unit_tb;
  import psc_pkg::*;

  localparam int          FP_LEN        = 32;
  localparam int          NUM_PHASES    = 7;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_CYCLES  = 200_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;
  // Lowest request type the block does not know
  localparam logic [3:0]  REQ_UNKNOWN   = REQ_EXPIRY_CHECK + 4'd1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  psc_req_if in_req ();
  psc_rsp_if out_rsp ();

  pairing_session_code_check_fsm_unit #(
    .ID_BITS        (64),
    .FINGERPRINT_LEN(FP_LEN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req),
    .out_rsp  (out_rsp)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Session predictor: register copies and the single session it tracks
  // --------------------------------------------------------------------------
  logic [15:0] lifetime   = 16'd300;
  logic [7:0]  try_budget = 8'd3;

  bit          ses_live     = 1'b0;
  logic [3:0]  ses_state    = SCODE_NONE;
  logic [63:0] ses_id       = '0;
  logic [19:0] ses_code     = '0;
  logic [31:0] ses_deadline = '0;
  logic [7:0]  ses_tries    = '0;
  logic [2:0]  ses_reason   = RSN_NONE;
  bit          ses_touched;
  bit          ses_lapsed;

  psc_rsp_t session_replies_due[$];
  psc_req_t request_backlog[$];

  int unsigned mismatch_count  = 0;
  int unsigned requests_taken  = 0;
  int unsigned replies_checked = 0;
  int unsigned opened_seen     = 0;
  int unsigned completed_seen  = 0;
  int unsigned expired_seen    = 0;
  int unsigned lockouts_seen   = 0;

  function automatic bit settled(logic [3:0] s);
    return s >= SCODE_COMPLETED;
  endfunction

  // Expire a live session whose deadline has been reached
  function automatic bit lapse_if_due(logic [31:0] now);
    if (!ses_live || settled(ses_state) || now < ses_deadline) return 1'b0;
    ses_state   = SCODE_EXPIRED;
    ses_reason  = RSN_EXPIRED;
    ses_touched = 1'b1;
    ses_lapsed  = 1'b1;
    return 1'b1;
  endfunction

  // ID match first; expiry is only looked at for the matching session
  function automatic logic [2:0] find_session(logic [63:0] id, logic [31:0] now);
    if (!ses_live || id == '0 || id != ses_id) return ERR_NOT_FOUND;
    if (lapse_if_due(now)) return ERR_EXPIRED;
    return ERR_OK;
  endfunction

  function automatic psc_rsp_t step_session(psc_req_t q);
    psc_rsp_t    o;
    logic [2:0]  err;
    logic [2:0]  why;
    logic [32:0] ceiling;
    logic [32:0] asked;
    logic [3:0]  need;
    logic [3:0]  next;
    ses_touched = 1'b0;
    ses_lapsed  = 1'b0;
    need        = SCODE_NONE;
    next        = SCODE_NONE;
    err         = ERR_OK;
    case (q.req_type)
      REQ_BEGIN, REQ_BEGIN_BOUND: begin
        // Sum kept one bit wider so the bound check sees an overflow
        ceiling = {1'b0, q.now_seconds} + 33'(lifetime);
        void'(lapse_if_due(q.now_seconds));
        if (ses_live && !settled(ses_state)) begin
          err = ERR_ACTIVE_EXISTS;
        end else if (q.fingerprint_bytes != 8'(FP_LEN)) begin
          err = ERR_BAD_FP;
        end else if (lifetime == '0 || try_budget == '0) begin
          err = ERR_INV_STATE;
        end else if ((q.code_present && !q.code_well_formed) ||
                     q.code_value >= CODE_LIMIT) begin
          err = ERR_BAD_CODE;
        end else begin
          asked = (q.req_type == REQ_BEGIN_BOUND) ? {1'b0, q.expiry_time} : ceiling;
          if (q.session_id == '0 || asked <= {1'b0, q.now_seconds} || asked > ceiling) begin
            err = ERR_INV_STATE;
          end else begin
            ses_live     = 1'b1;
            ses_id       = q.session_id;
            ses_state    = SCODE_REQUESTING;
            ses_code     = q.code_value;
            ses_deadline = asked[32] ? '1 : asked[31:0];
            ses_tries    = try_budget;
            ses_reason   = RSN_NONE;
            ses_touched  = 1'b1;
          end
        end
      end
      REQ_XPORT_READY, REQ_XCRIPT_DONE, REQ_CONFIRM, REQ_COMPLETE: begin
        case (q.req_type)
          REQ_XPORT_READY: begin
            need = SCODE_REQUESTING;
            next = SCODE_EXCHANGING;
          end
          REQ_XCRIPT_DONE: begin
            need = SCODE_EXCHANGING;
            next = SCODE_AWAIT_CMP;
          end
          REQ_CONFIRM: begin
            need = SCODE_AWAIT_CMP;
            next = SCODE_CONFIRMING;
          end
          default: begin
            need = SCODE_CONFIRMING;
            next = SCODE_COMPLETED;
          end
        endcase
        err = find_session(q.session_id, q.now_seconds);
        if (err == ERR_OK) begin
          if (ses_state != need) begin
            err = ERR_INV_STATE;
          end else begin
            ses_state   = next;
            ses_touched = 1'b1;
          end
        end
      end
      REQ_SUBMIT: begin
        err = find_session(q.session_id, q.now_seconds);
        if (err == ERR_OK) begin
          if (ses_state != SCODE_AWAIT_CMP) begin
            err = ERR_INV_STATE;
          end else if (!q.code_well_formed || q.code_value >= CODE_LIMIT) begin
            err = ERR_BAD_CODE;
          end else if (q.code_value != ses_code) begin
            ses_tries   = ses_tries - 8'd1;
            ses_touched = 1'b1;
            if (ses_tries == '0) begin
              ses_state  = SCODE_REJECTED;
              ses_reason = RSN_ATTEMPTS;
              err        = ERR_EXHAUSTED;
            end else begin
              err = ERR_BAD_CODE;
            end
          end else begin
            ses_state   = SCODE_CONFIRMING;
            ses_touched = 1'b1;
          end
        end
      end
      REQ_CANCEL, REQ_REJECT, REQ_FAIL: begin
        next = (q.req_type == REQ_FAIL) ? SCODE_FAILED : SCODE_REJECTED;
        why  = (q.req_type == REQ_CANCEL) ? RSN_CANCELLED : q.reason_code;
        err  = find_session(q.session_id, q.now_seconds);
        if (err == ERR_OK) begin
          if (settled(ses_state) || why == RSN_NONE) begin
            err = ERR_INV_STATE;
          end else begin
            ses_state   = next;
            ses_reason  = why;
            ses_touched = 1'b1;
          end
        end
      end
      REQ_EXPIRY_CHECK: begin
        void'(lapse_if_due(q.now_seconds));
        err = ERR_OK;
      end
      default: begin
        err = ERR_INV_STATE;
      end
    endcase
    o.error_code     = err;
    o.expired_now    = ses_lapsed;
    o.session_state  = ses_live ? ses_state : SCODE_NONE;
    o.failure_reason = ses_live ? ses_reason : RSN_NONE;
    o.attempts_left  = ses_live ? ses_tries : 8'd0;
    o.changed        = ses_touched;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, a few long; calm mode gives none at all
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer backlog items, predict each accepted transaction
  // --------------------------------------------------------------------------
  int unsigned req_gap  = 0;
  bit          req_calm = 1'b0;
  psc_rsp_t    fresh_reply;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      // Track register writes; they only happen with the block idle
      if (cfg_wr_en) begin
        if (cfg_index == CFG_VALIDITY) lifetime = cfg_wdata;
        else if (cfg_index == CFG_MAX_ATTEMPTS) try_budget = cfg_wdata[7:0];
      end
      if (in_req.valid && in_req.ready) begin
        fresh_reply = step_session(in_req.data);
        session_replies_due.push_back(fresh_reply);
        requests_taken++;
        if (fresh_reply.expired_now) expired_seen++;
        if (fresh_reply.error_code == ERR_EXHAUSTED) lockouts_seen++;
        if (fresh_reply.error_code == ERR_OK) begin
          if (in_req.data.req_type == REQ_BEGIN || in_req.data.req_type == REQ_BEGIN_BOUND)
            opened_seen++;
          if (in_req.data.req_type == REQ_COMPLETE) completed_seen++;
        end
      end
      // Hold a pending offer until it is taken; otherwise pick the next move
      if (!in_req.valid || in_req.ready) begin
        if (req_gap != 0) begin
          req_gap--;
          in_req.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          in_req.data  <= request_backlog.pop_front();
          in_req.valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
          req_gap = draw_gap(req_calm);
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  int unsigned rsp_gap  = 0;
  bit          rsp_calm = 1'b0;
  bit          rsp_hold = 1'b0;
  psc_rsp_t    due_reply;

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (session_replies_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatch_count++;
        end else begin
          due_reply = session_replies_due.pop_front();
          check_field("error_code", due_reply.error_code, out_rsp.data.error_code);
          check_field("expired_now", due_reply.expired_now, out_rsp.data.expired_now);
          check_field("session_state", due_reply.session_state, out_rsp.data.session_state);
          check_field("failure_reason", due_reply.failure_reason,
                      out_rsp.data.failure_reason);
          check_field("attempts_left", due_reply.attempts_left, out_rsp.data.attempts_left);
          check_field("changed", due_reply.changed, out_rsp.data.changed);
          replies_checked++;
        end
      end
      if (rsp_hold) begin
        out_rsp.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
        rsp_gap--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
        rsp_gap = draw_gap(rsp_calm);
      end
    end
  end

  // Long receiver stall while the sender keeps offering: fill the block up
  bit squeeze_go = 1'b0;

  initial begin
    wait (squeeze_go);
    repeat (20) @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus planning: a rough view of time and the session being built
  // --------------------------------------------------------------------------
  logic [31:0] plan_clock = 32'd5000;
  logic [63:0] plan_id    = 64'd1;
  int unsigned plan_life  = 300;
  int unsigned plan_tries = 3;
  int unsigned planned    = 0;

  function automatic psc_req_t base_req(logic [3:0] kind, logic [31:0] now, logic [63:0] id);
    psc_req_t r;
    r                   = '0;
    r.req_type          = kind;
    r.now_seconds       = now;
    r.session_id        = id;
    r.fingerprint_bytes = 8'(FP_LEN);
    r.code_well_formed  = 1'b1;
    r.reason_code       = 3'($urandom_range(1, 7));
    return r;
  endfunction

  function automatic void push_req(psc_req_t r);
    request_backlog.push_back(r);
    planned++;
  endfunction

  // Anything goes: every field random, time and ID sometimes unrelated
  function automatic psc_req_t noise_req();
    psc_req_t r;
    r.req_type    = 4'($urandom_range(0, 15));
    r.now_seconds = ($urandom_range(0, 7) == 0) ? $urandom : plan_clock;
    case ($urandom_range(0, 2))
      0:       r.session_id = '0;
      1:       r.session_id = plan_id;
      default: r.session_id = {$urandom, $urandom};
    endcase
    r.expiry_time = $urandom_range(0, 1) ? $urandom
                                         : plan_clock + 32'($urandom_range(0, plan_life + 2));
    r.fingerprint_bytes = $urandom_range(0, 1) ? 8'(FP_LEN) : 8'($urandom_range(0, 255));
    r.code_present      = 1'($urandom_range(0, 1));
    r.code_well_formed  = 1'($urandom_range(0, 1));
    r.code_value        = $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 999999));
    r.reason_code       = 3'($urandom_range(0, 7));
    return r;
  endfunction

  // One session walked through its life with random detours and time steps
  task automatic queue_session();
    logic [3:0]  path [5];
    logic [19:0] code;
    psc_req_t    r;
    int unsigned roll;
    int unsigned misses;
    path = '{REQ_XPORT_READY, REQ_XCRIPT_DONE, REQ_CONFIRM, REQ_SUBMIT, REQ_COMPLETE};
    do plan_id = {$urandom, $urandom}; while (plan_id == '0);
    code = 20'($urandom_range(0, 999999));
    plan_clock += 32'($urandom_range(0, plan_life + 5));
    r = base_req($urandom_range(0, 1) ? REQ_BEGIN_BOUND : REQ_BEGIN, plan_clock, plan_id);
    r.code_present = 1'($urandom_range(0, 1));
    r.code_value   = code;
    r.expiry_time  = plan_clock + 32'($urandom_range(1, plan_life + 1));
    push_req(r);
    foreach (path[i]) begin
      // Advance time; now and then jump a whole lifetime to force expiry
      plan_clock += ($urandom_range(0, 15) == 0) ? 32'(plan_life)
                                                 : 32'($urandom_range(0, plan_life / 4 + 1));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        push_req(noise_req());
      end else if (roll < 10) begin
        push_req(base_req(path[i], plan_clock, plan_id ^ (64'd1 << $urandom_range(0, 63))));
      end else if (roll < 16) begin
        // Drop the session early by cancel, reject or fail
        r = base_req(REQ_CANCEL + 4'($urandom_range(0, 2)), plan_clock, plan_id);
        r.reason_code = 3'($urandom_range(0, 7));
        push_req(r);
        return;
      end
      if (path[i] == REQ_SUBMIT) begin
        misses = $urandom_range(0, plan_tries < 4 ? plan_tries : 4);
        repeat (misses) begin
          r = base_req(REQ_SUBMIT, plan_clock, plan_id);
          r.code_value = 20'((int'(code) + $urandom_range(1, 999999)) % 1000000);
          if ($urandom_range(0, 9) == 0) r.code_well_formed = 1'b0;
          push_req(r);
        end
      end
      r = base_req(path[i], plan_clock, plan_id);
      r.code_value = code;
      push_req(r);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for the backlog to drain and every predicted result to arrive
  task automatic drain_pipeline();
    int unsigned waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((request_backlog.size() != 0 || in_req.valid ||
                session_replies_due.size() != 0) && waited < DRAIN_CYCLES);
    if (request_backlog.size() != 0 || in_req.valid || session_replies_due.size() != 0) begin
      $error("%0d results still outstanding after %0d cycles",
             session_replies_due.size(), waited);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Register settings per phase; zero in both tables of phase 5 means random
  // --------------------------------------------------------------------------
  int unsigned phase_life  [NUM_PHASES] = '{300, 65535, 1, 0, 20, 0, 60};
  int unsigned phase_tries [NUM_PHASES] = '{3, 255, 1, 5, 0, 0, 2};
  int unsigned phase_items [NUM_PHASES] = '{130, 130, 130, 40, 40, 130, 130};

  initial begin
    psc_req_t r;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    out_rsp.ready = 1'b0;

    // Directed part, reset register values (300 s, 3 attempts)
    push_req(base_req(REQ_EXPIRY_CHECK, 32'd0, 64'd0));
    push_req(base_req(REQ_XPORT_READY, 32'd0, 64'd5));
    push_req(base_req(REQ_UNKNOWN, 32'd0, '1));
    push_req(base_req('1, 32'd0, '1));
    // Begin rejections: fingerprint length, malformed and out-of-range codes,
    // null ID, bound expiry at now and past the lifetime
    r = base_req(REQ_BEGIN, 32'd100, '1);
    r.fingerprint_bytes = 8'(FP_LEN - 1);
    push_req(r);
    r = base_req(REQ_BEGIN, 32'd100, '1);
    r.code_present     = 1'b1;
    r.code_well_formed = 1'b0;
    push_req(r);
    r = base_req(REQ_BEGIN, 32'd100, '1);
    r.code_present = 1'b1;
    r.code_value   = CODE_LIMIT;
    push_req(r);
    r = base_req(REQ_BEGIN, 32'd100, '1);
    r.code_value = '1;
    push_req(r);
    push_req(base_req(REQ_BEGIN, 32'd100, 64'd0));
    r = base_req(REQ_BEGIN_BOUND, 32'd100, '1);
    r.expiry_time = 32'd100;
    push_req(r);
    r = base_req(REQ_BEGIN_BOUND, 32'd100, '1);
    r.expiry_time = 32'd401;
    push_req(r);
    // Begin near the top of time: the expiry saturates
    r = base_req(REQ_BEGIN, 32'hFFFF_FF00, '1);
    r.code_present = 1'b1;
    r.code_value   = CODE_LIMIT - 20'd1;
    push_req(r);
    push_req(base_req(REQ_BEGIN_BOUND, 32'hFFFF_FF00, 64'd2));
    push_req(base_req(REQ_XPORT_READY, 32'hFFFF_FF10, 64'hFFFF_FFFF_FFFF_FFFE));
    push_req(base_req(REQ_CONFIRM, 32'hFFFF_FF10, '1));
    push_req(base_req(REQ_XPORT_READY, 32'hFFFF_FF10, '1));
    push_req(base_req(REQ_XCRIPT_DONE, 32'hFFFF_FF10, '1));
    // Flagged well formed yet too large: no attempt used
    r = base_req(REQ_SUBMIT, 32'hFFFF_FF20, '1);
    r.code_value = CODE_LIMIT;
    push_req(r);
    r = base_req(REQ_SUBMIT, 32'hFFFF_FF20, '1);
    r.code_well_formed = 1'b0;
    r.code_value       = CODE_LIMIT - 20'd1;
    push_req(r);
    push_req(base_req(REQ_SUBMIT, 32'hFFFF_FF20, '1));
    r = base_req(REQ_SUBMIT, 32'hFFFF_FF20, '1);
    r.code_value = CODE_LIMIT - 20'd1;
    push_req(r);
    r = base_req(REQ_REJECT, 32'hFFFF_FF30, '1);
    r.reason_code = RSN_NONE;
    push_req(r);
    push_req(base_req(REQ_COMPLETE, 32'hFFFF_FF30, '1));
    r = base_req(REQ_FAIL, 32'hFFFF_FF30, '1);
    r.reason_code = '1;
    push_req(r);
    push_req(base_req(REQ_EXPIRY_CHECK, '1, '1));
    // Bound session that expires exactly at its deadline on a submit
    r = base_req(REQ_BEGIN_BOUND, 32'd1000, 64'h8000_0000_0000_0000);
    r.expiry_time = 32'd1300;
    push_req(r);
    push_req(base_req(REQ_SUBMIT, 32'd1300, 64'h8000_0000_0000_0000));
    // A begin that first expires the live session, then replaces it
    push_req(base_req(REQ_BEGIN, 32'd2000, 64'd3));
    push_req(base_req(REQ_BEGIN, 32'd2300, 64'd4));
    push_req(base_req(REQ_CANCEL, 32'd2301, 64'd4));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain_pipeline();
        plan_life  = phase_life[p];
        plan_tries = phase_tries[p];
        if (plan_life == 0 && plan_tries == 0) begin
          plan_life  = $urandom_range(2, 2000);
          plan_tries = $urandom_range(1, 6);
        end
        write_register(CFG_VALIDITY, 16'(plan_life));
        // Upper byte is junk; only the low byte belongs to the register
        write_register(CFG_MAX_ATTEMPTS, {8'($urandom), 8'(plan_tries)});
        if (p == 1) squeeze_go = 1'b1;
      end
      planned = 0;
      while (planned < phase_items[p]) begin
        if ($urandom_range(0, 99) < 85) queue_session();
        else push_req(noise_req());
      end
    end

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d requests over %0d register settings, %0d results checked.",
             requests_taken, NUM_PHASES, replies_checked);
    $display("Sessions: %0d opened, %0d completed, %0d expired, %0d locked out by codes.",
             opened_seen, completed_seen, expired_seen, lockouts_seen);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
